// File: rtl/sbsl_pkg.sv
// Package for the star brightness sorted list: payload structs, config indexes,
// constants and the front-to-back command struct. No dependencies.
package sbsl_pkg;

	localparam int LIST_DEPTH = 255;
	localparam int DEPTH_W = 8;
	localparam int ADDR_W = 9;
	localparam int MEM_DEPTH = 2 * LIST_DEPTH;
	localparam logic [7:0] RANK_NONE = 8'd255;

	localparam logic [2:0] CFG_TAN_X = 3'd0;
	localparam logic [2:0] CFG_TAN_Y = 3'd1;
	localparam logic [2:0] CFG_BASE_VAR = 3'd2;
	localparam logic [2:0] CFG_NOISE_VAR = 3'd3;
	localparam logic [2:0] CFG_LIMIT = 3'd4;

	typedef struct packed {
		logic mode;
		logic list_sel;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0] brightness;
		logic [7:0] rank_query;
	} in_item_t;

	typedef struct packed {
		logic valid_res;
		logic [7:0] rank;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [31:0] spread;
		logic [15:0] star_bright;
		logic [15:0] arrival;
		logic signed [15:0] star_pos_x;
		logic signed [15:0] star_pos_y;
		logic [7:0] list_size;
	} out_item_t;

	// stored list entry
	typedef struct packed {
		logic [31:0] dir_x;
		logic [31:0] dir_y;
		logic [31:0] dir_z;
		logic [31:0] spread;
		logic [15:0] bright;
		logic [15:0] arrival;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} entry_t;

	// command handed from front to back
	typedef struct packed {
		logic mode;
		logic list_sel;
		logic [7:0] rank_query;
		entry_t ent;
	} cmd_t;

	typedef enum logic [3:0] {
		F_IDLE, F_MULJ, F_MULK, F_SQJ, F_SQK, F_SQRT, F_DIV, F_MULY, F_MULZ,
		F_QUO, F_DONE
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_RDREQ, B_RDWAIT, B_SCAN, B_SCANW, B_SHIFT, B_SHIFTW, B_WRITE,
		B_OUT
	} back_state_t;

endpackage

// File: rtl/star_brightness_sorted_list_top.sv
// Top level of the star brightness sorted list.
// Depends on sbsl_pkg, sbsl_front, sbsl_queue and sbsl_back.
// An insert runs first through the front (bit-serial square root and
// divisions) and then through the back (scan and shift of the list memory,
// one entry at a time); a read passes through the front without computing.
// Front and back overlap through a two-entry queue; the result is held until popped.
module star_brightness_sorted_list_top (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  sbsl_pkg::in_item_t in_data,
	output logic empty,
	input  logic pop,
	output sbsl_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] tan_x_q, tan_y_q, base_var_q, noise_var_q;
	logic [7:0] limit_q;
	logic in_ready, f_valid, f_ready, b_valid, b_ready;
	sbsl_pkg::cmd_t f_cmd, b_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_x_q <= '0;
			tan_y_q <= '0;
			base_var_q <= '0;
			noise_var_q <= '0;
			limit_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				sbsl_pkg::CFG_TAN_X: tan_x_q <= cfg_data;
				sbsl_pkg::CFG_TAN_Y: tan_y_q <= cfg_data;
				sbsl_pkg::CFG_BASE_VAR: base_var_q <= cfg_data;
				sbsl_pkg::CFG_NOISE_VAR: noise_var_q <= cfg_data;
				sbsl_pkg::CFG_LIMIT: limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign full = !in_ready;

	sbsl_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push), .in_ready(in_ready), .in_item(in_data),
		.tan_x(tan_x_q), .tan_y(tan_y_q), .base_var(base_var_q), .noise_var(noise_var_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	sbsl_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	sbsl_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.limit(limit_q), .empty(empty), .pop(pop), .res(out_data)
	);
endmodule

// File: rtl/sbsl_front.sv
// Front part: accepts transactions, computes direction and spread for inserts.
// Depends on sbsl_pkg.
module sbsl_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sbsl_pkg::in_item_t in_item,
	input  logic [31:0] tan_x,
	input  logic [31:0] tan_y,
	input  logic [31:0] base_var,
	input  logic [31:0] noise_var,
	output logic cmd_valid,
	input  logic cmd_ready,
	output sbsl_pkg::cmd_t cmd
);
	sbsl_pkg::front_state_t state_q, state_d;
	sbsl_pkg::in_item_t item_q;
	logic [15:0] mx_q, my_q;
	logic [31:0] jq_q, kq_q;
	logic [63:0] s_q, v_q, res_q, bit_q, prod_q;
	logic [58:0] num_q;
	logic [58:0] rem_q;
	logic [31:0] x30_q;
	logic [5:0] cnt_q;
	logic [31:0] qrem_q;
	logic [31:0] quo_q;
	logic [31:0] dy_q, dz_q;

	logic [63:0] trial;
	logic [59:0] rsh;
	logic [32:0] qsh;
	logic [32:0] spsum;

	assign trial = res_q + bit_q;
	assign rsh = {rem_q, num_q[58]};
	assign qsh = {qrem_q, quo_q[31]};
	assign spsum = {1'b0, base_var} + {1'b0, quo_q};
	assign in_ready = (state_q == sbsl_pkg::F_IDLE);
	assign cmd_valid = (state_q == sbsl_pkg::F_DONE);

	always_comb begin
		cmd = '0;
		cmd.mode = item_q.mode;
		cmd.list_sel = item_q.list_sel;
		cmd.rank_query = item_q.rank_query;
		cmd.ent.dir_x = x30_q;
		cmd.ent.dir_y = dy_q;
		cmd.ent.dir_z = dz_q;
		cmd.ent.spread = spsum[32] ? 32'hFFFF_FFFF : spsum[31:0];
		cmd.ent.bright = item_q.brightness;
		cmd.ent.pos_x = item_q.pos_x;
		cmd.ent.pos_y = item_q.pos_y;
		cmd.ent.arrival = '0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sbsl_pkg::F_IDLE: if (in_valid) state_d = in_item.mode ? sbsl_pkg::F_DONE
				: sbsl_pkg::F_MULJ;
			sbsl_pkg::F_MULJ: state_d = sbsl_pkg::F_MULK;
			sbsl_pkg::F_MULK: state_d = sbsl_pkg::F_SQJ;
			sbsl_pkg::F_SQJ: state_d = sbsl_pkg::F_SQK;
			sbsl_pkg::F_SQK: state_d = sbsl_pkg::F_SQRT;
			sbsl_pkg::F_SQRT: if (bit_q == 64'd0) state_d = sbsl_pkg::F_DIV;
			sbsl_pkg::F_DIV: if (cnt_q == 6'd58) state_d = sbsl_pkg::F_MULY;
			sbsl_pkg::F_MULY: state_d = sbsl_pkg::F_MULZ;
			sbsl_pkg::F_MULZ: state_d = sbsl_pkg::F_QUO;
			sbsl_pkg::F_QUO: if (cnt_q == 6'd31) state_d = sbsl_pkg::F_DONE;
			sbsl_pkg::F_DONE: if (cmd_ready) state_d = sbsl_pkg::F_IDLE;
			default: state_d = sbsl_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sbsl_pkg::F_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sbsl_pkg::F_IDLE: begin
				item_q <= in_item;
				mx_q <= in_item.pos_x[15] ? 16'(-in_item.pos_x) : in_item.pos_x;
				my_q <= in_item.pos_y[15] ? 16'(-in_item.pos_y) : in_item.pos_y;
				x30_q <= '0;
				dy_q <= '0;
				dz_q <= '0;
				quo_q <= '0;
			end
			sbsl_pkg::F_MULJ: jq_q <= 32'(({32'd0, mx_q} * {16'd0, tan_x}) >> 16);
			sbsl_pkg::F_MULK: kq_q <= 32'(({32'd0, my_q} * {16'd0, tan_y}) >> 16);
			sbsl_pkg::F_SQJ: s_q <= (64'd1 << 56) + 64'(jq_q * jq_q);
			sbsl_pkg::F_SQK: begin
				v_q <= s_q + 64'(kq_q * kq_q);
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			sbsl_pkg::F_SQRT: begin
				if (bit_q != 0) begin
					if (v_q >= trial) begin
						v_q <= v_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else res_q <= res_q >> 1;
					bit_q <= bit_q >> 2;
				end else begin
					num_q <= 59'd1 << 58;
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			sbsl_pkg::F_DIV: begin
				num_q <= num_q << 1;
				if ({4'd0, rsh} >= res_q) begin
					rem_q <= 59'({4'd0, rsh} - res_q);
					x30_q <= {x30_q[30:0], 1'b1};
				end else begin
					rem_q <= rsh[58:0];
					x30_q <= {x30_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			sbsl_pkg::F_MULY: begin
				prod_q <= 64'(({32'd0, jq_q} * {32'd0, x30_q}) >> 28);
			end
			sbsl_pkg::F_MULZ: begin
				dy_q <= item_q.pos_x[15] ? 32'(-prod_q[31:0]) : prod_q[31:0];
				prod_q <= 64'(({32'd0, kq_q} * {32'd0, x30_q}) >> 28);
				quo_q <= noise_var;
				qrem_q <= '0;
				cnt_q <= '0;
			end
			sbsl_pkg::F_QUO: begin
				if (cnt_q == 6'd0)
					dz_q <= item_q.pos_y[15] ? 32'(-prod_q[31:0]) : prod_q[31:0];
				if (item_q.brightness == 16'd0) begin
					quo_q <= 32'hFFFF_FFFF;
				end else if (qsh >= {17'd0, item_q.brightness}) begin
					qrem_q <= 32'(qsh - {17'd0, item_q.brightness});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					qrem_q <= qsh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end
endmodule

// File: rtl/sbsl_queue.sv
// Two-entry command queue between front and back. Depends on sbsl_pkg.
module sbsl_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  sbsl_pkg::cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output sbsl_pkg::cmd_t rd_data
);
	sbsl_pkg::cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end
endmodule

// File: rtl/sbsl_back.sv
// Back part: holds both sorted lists in a memory, inserts and reads entries,
// and keeps the result register. Depends on sbsl_pkg.
module sbsl_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  sbsl_pkg::cmd_t cmd,
	input  logic [7:0] limit,
	output logic empty,
	input  logic pop,
	output sbsl_pkg::out_item_t res
);
	sbsl_pkg::back_state_t state_q, state_d;
	sbsl_pkg::entry_t mem [sbsl_pkg::MEM_DEPTH];
	sbsl_pkg::entry_t rdata_s1;
	logic [sbsl_pkg::ADDR_W-1:0] raddr, waddr;
	logic we;
	sbsl_pkg::entry_t wdata;

	sbsl_pkg::cmd_t c_q;
	logic [7:0] count_q [2];
	logic [15:0] arr_q [2];
	logic [7:0] pos_q, idx_q, cnt_now, eff_lim, newcount;
	logic [15:0] stamp_q;
	logic full_q;
	sbsl_pkg::out_item_t res_q, hold_q, ins_res, rd_res;

	logic [sbsl_pkg::ADDR_W-1:0] base;
	assign base = c_q.list_sel ? sbsl_pkg::ADDR_W'(sbsl_pkg::LIST_DEPTH) : '0;
	assign cnt_now = count_q[c_q.list_sel];
	assign eff_lim = (limit > 8'(sbsl_pkg::LIST_DEPTH)) ? 8'(sbsl_pkg::LIST_DEPTH) : limit;
	assign newcount = ({1'b0, cnt_now} + 9'd1 < {1'b0, eff_lim}) ? cnt_now + 8'd1 : eff_lim;

	assign cmd_ready = (state_q == sbsl_pkg::B_IDLE);
	assign empty = !full_q;
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	always_comb begin
		ins_res = '0;
		ins_res.valid_res = pos_q < newcount;
		ins_res.rank = (pos_q < newcount) ? pos_q : sbsl_pkg::RANK_NONE;
		ins_res.dir_x = c_q.ent.dir_x;
		ins_res.dir_y = c_q.ent.dir_y;
		ins_res.dir_z = c_q.ent.dir_z;
		ins_res.spread = c_q.ent.spread;
		ins_res.star_bright = c_q.ent.bright;
		ins_res.arrival = stamp_q;
		ins_res.star_pos_x = c_q.ent.pos_x;
		ins_res.star_pos_y = c_q.ent.pos_y;
		ins_res.list_size = newcount;
		rd_res = '0;
		rd_res.list_size = cnt_now;
		rd_res.rank = sbsl_pkg::RANK_NONE;
		if (c_q.rank_query < cnt_now && c_q.rank_query < 8'(sbsl_pkg::LIST_DEPTH)) begin
			rd_res.valid_res = 1'b1;
			rd_res.rank = c_q.rank_query;
			rd_res.dir_x = rdata_s1.dir_x;
			rd_res.dir_y = rdata_s1.dir_y;
			rd_res.dir_z = rdata_s1.dir_z;
			rd_res.spread = rdata_s1.spread;
			rd_res.star_bright = rdata_s1.bright;
			rd_res.arrival = rdata_s1.arrival;
			rd_res.star_pos_x = rdata_s1.pos_x;
			rd_res.star_pos_y = rdata_s1.pos_y;
		end
	end

	always_comb begin
		state_d = state_q;
		raddr = base + sbsl_pkg::ADDR_W'(idx_q);
		waddr = base + sbsl_pkg::ADDR_W'(idx_q);
		we = 1'b0;
		wdata = rdata_s1;
		case (state_q)
			sbsl_pkg::B_IDLE: if (cmd_valid) state_d = sbsl_pkg::B_RDREQ;
			sbsl_pkg::B_RDREQ: begin
				if (c_q.mode) begin
					raddr = base + sbsl_pkg::ADDR_W'(c_q.rank_query);
					state_d = sbsl_pkg::B_RDWAIT;
				end else state_d = sbsl_pkg::B_SCAN;
			end
			sbsl_pkg::B_RDWAIT: state_d = sbsl_pkg::B_OUT;
			sbsl_pkg::B_SCAN: begin
				if (idx_q < cnt_now && idx_q < 8'(sbsl_pkg::LIST_DEPTH))
					state_d = sbsl_pkg::B_SCANW;
				else state_d = sbsl_pkg::B_SHIFT;
			end
			sbsl_pkg::B_SCANW: begin
				if (rdata_s1.bright >= c_q.ent.bright) state_d = sbsl_pkg::B_SCAN;
				else state_d = sbsl_pkg::B_SHIFT;
			end
			sbsl_pkg::B_SHIFT: begin
				raddr = base + sbsl_pkg::ADDR_W'(idx_q - 8'd1);
				if (idx_q > pos_q) state_d = sbsl_pkg::B_SHIFTW;
				else state_d = sbsl_pkg::B_WRITE;
			end
			sbsl_pkg::B_SHIFTW: begin
				we = 1'b1;
				state_d = sbsl_pkg::B_SHIFT;
			end
			sbsl_pkg::B_WRITE: begin
				waddr = base + sbsl_pkg::ADDR_W'(pos_q);
				wdata = c_q.ent;
				wdata.arrival = stamp_q;
				we = (pos_q < 8'(sbsl_pkg::LIST_DEPTH));
				state_d = sbsl_pkg::B_OUT;
			end
			sbsl_pkg::B_OUT: if (!full_q || pop) state_d = sbsl_pkg::B_IDLE;
			default: state_d = sbsl_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbsl_pkg::B_IDLE;
			count_q[0] <= '0;
			count_q[1] <= '0;
			arr_q[0] <= '0;
			arr_q[1] <= '0;
			full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sbsl_pkg::B_OUT && (!full_q || pop)) full_q <= 1'b1;
			else if (pop && full_q) full_q <= 1'b0;
			case (state_q)
				sbsl_pkg::B_RDREQ: if (!c_q.mode) begin
					stamp_q <= (cnt_now == 0) ? 16'd0 : arr_q[c_q.list_sel];
					if (cnt_now == 0) arr_q[c_q.list_sel] <= 16'd1;
					else if (arr_q[c_q.list_sel] != 16'hFFFF)
						arr_q[c_q.list_sel] <= arr_q[c_q.list_sel] + 16'd1;
				end
				sbsl_pkg::B_WRITE: count_q[c_q.list_sel] <= newcount;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sbsl_pkg::B_IDLE: begin
				c_q <= cmd;
				idx_q <= '0;
			end
			sbsl_pkg::B_SCAN: pos_q <= idx_q;
			sbsl_pkg::B_SCANW: begin
				if (rdata_s1.bright >= c_q.ent.bright) idx_q <= idx_q + 8'd1;
				else idx_q <= (cnt_now < 8'(sbsl_pkg::LIST_DEPTH - 1)) ? cnt_now
					: 8'(sbsl_pkg::LIST_DEPTH - 1);
			end
			sbsl_pkg::B_SHIFTW: idx_q <= idx_q - 8'd1;
			default: ;
		endcase
		if (state_q == sbsl_pkg::B_SCAN && !(idx_q < cnt_now &&
			idx_q < 8'(sbsl_pkg::LIST_DEPTH)))
			idx_q <= (cnt_now < 8'(sbsl_pkg::LIST_DEPTH - 1)) ? cnt_now
				: 8'(sbsl_pkg::LIST_DEPTH - 1);
		if (state_q == sbsl_pkg::B_WRITE) hold_q <= ins_res;
		if (state_q == sbsl_pkg::B_RDWAIT) hold_q <= rd_res;
		// result register only loads once the previous transaction has left
		if (state_q == sbsl_pkg::B_OUT && (!full_q || pop)) res_q <= hold_q;
	end
endmodule

// File: rtl/sbsl_checker.sv
// Port-level checker for the star brightness sorted list, bound to the top.
// Depends on sbsl_pkg and star_brightness_sorted_list_top.
module sbsl_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input sbsl_pkg::out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_data)))
		else $error("result changed while waiting");
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_data.valid_res) |-> (out_data.rank == sbsl_pkg::RANK_NONE))
		else $error("invalid result without rank 255");
	a_rankok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.valid_res) |-> (out_data.rank < out_data.list_size))
		else $error("rank beyond list size");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("accepted two transactions back to back");
endmodule

bind star_brightness_sorted_list_top sbsl_checker u_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty), .pop(pop),
	.out_data(out_data)
);
